/* design/bsce_pkg.sv */
// Package for the boxcar smoother: payload structs, the front-to-back command
// struct and fixed widths. No dependencies.
package bsce_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int CNT_BITS     = 7;
    localparam int SUM_BITS     = 22;
    localparam int DIV_CNT_BITS = 5;

    localparam logic [CNT_BITS-1:0] POS_SAT     = 7'd127;
    localparam logic [CNT_BITS-1:0] WIDTH_RESET = 7'd5;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   frame_end;
    } t_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] smoothed;
        logic                   last_out;
    } t_result;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [SAMPLE_BITS-1:0] edge_smp;
        logic                   last;
        logic                   pass;
        logic                   has_out;
        logic [CNT_BITS-1:0]    w;
        logic [CNT_BITS-1:0]    half;
        logic [CNT_BITS-1:0]    e_first;
        logic [CNT_BITS-1:0]    p;
    } t_cmd;

endpackage

/* design/bsce_fifo.sv */
// Small synchronous FIFO used for the command queue and the result queue.
// Depends on nothing.
module bsce_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* design/bsce_div.sv */
// Restoring divider, one quotient bit per cycle, for window sum over width.
// Depends on bsce_pkg.
module bsce_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [bsce_pkg::SUM_BITS-1:0]     i_dividend,
    input  logic [bsce_pkg::CNT_BITS-1:0]     i_divisor,
    output logic                              o_done,
    output logic [bsce_pkg::SUM_BITS-1:0]     o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [bsce_pkg::DIV_CNT_BITS-1:0] r_cnt;
    logic [bsce_pkg::CNT_BITS-1:0]     r_rem;
    logic [bsce_pkg::CNT_BITS-1:0]     r_dvs;
    logic [bsce_pkg::SUM_BITS-1:0]     r_quo;
    logic [bsce_pkg::CNT_BITS:0]       shifted;
    logic [bsce_pkg::CNT_BITS:0]       diff;
    logic                              ge;

    assign shifted    = {r_rem, r_quo[bsce_pkg::SUM_BITS-1]};
    assign ge         = (shifted >= {1'b0, r_dvs});
    assign diff       = shifted - {1'b0, r_dvs};
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == bsce_pkg::DIV_CNT_BITS'(bsce_pkg::SUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[bsce_pkg::CNT_BITS-1:0] : shifted[bsce_pkg::CNT_BITS-1:0];
            r_quo <= {r_quo[bsce_pkg::SUM_BITS-2:0], ge};
        end
    end

endmodule

/* design/bsce_front.sv */
// Front part: holds the width register and frame state, accepts samples and
// turns each into a command for the back part. Depends on bsce_pkg.
module bsce_front #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bsce_pkg::CNT_BITS-1:0] i_cfg_wdata,
    input  logic                          i_push,
    input  bsce_pkg::t_item               i_item,
    input  logic                          i_q_full,
    output logic                          o_cmd_push,
    output bsce_pkg::t_cmd                o_cmd
);

    logic [bsce_pkg::CNT_BITS-1:0]    r_width;
    logic [bsce_pkg::CNT_BITS-1:0]    r_pos;
    logic [bsce_pkg::SAMPLE_BITS-1:0] r_edge;
    logic                             r_frame_start;

    logic [bsce_pkg::CNT_BITS-1:0]    w;
    logic [bsce_pkg::CNT_BITS-1:0]    half;
    logic [bsce_pkg::CNT_BITS-1:0]    lag;
    logic [bsce_pkg::CNT_BITS-1:0]    n_pos;
    logic [bsce_pkg::CNT_BITS-1:0]    p;
    logic [bsce_pkg::SAMPLE_BITS-1:0] n_edge;
    logic                             accept;

    assign accept     = i_push && !i_q_full;
    assign o_cmd_push = accept;

    always_comb begin
        w = r_width;
        if (int'(r_width) > MAX_WIDTH) begin
            w = bsce_pkg::CNT_BITS'(MAX_WIDTH);
        end
        half = w >> 1;
        lag  = w - 7'd1 - half;
        if (r_frame_start) begin
            n_pos  = 7'd1;
            n_edge = i_item.sample;
        end else begin
            n_pos  = (r_pos < bsce_pkg::POS_SAT) ? r_pos + 7'd1 : r_pos;
            n_edge = r_edge;
        end
        p = n_pos - 7'd1;

        o_cmd.sample   = i_item.sample;
        o_cmd.edge_smp = n_edge;
        o_cmd.last     = i_item.frame_end;
        o_cmd.pass     = (w <= 7'd1);
        o_cmd.has_out  = i_item.frame_end || (p >= lag);
        o_cmd.w        = w;
        o_cmd.half     = half;
        o_cmd.e_first  = (i_item.frame_end && (p < lag)) ? p : lag;
        o_cmd.p        = p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= bsce_pkg::WIDTH_RESET;
            r_pos         <= '0;
            r_edge        <= '0;
            r_frame_start <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
            if (accept) begin
                r_pos         <= n_pos;
                r_edge        <= n_edge;
                r_frame_start <= i_item.frame_end;
            end
        end
    end

endmodule

/* design/bsce_back.sv */
// Back part: owns the sample ring, sums each window one sample per cycle and
// divides by the width. Depends on bsce_pkg and bsce_div.
module bsce_back #(
    parameter int MAX_WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_empty,
    input  bsce_pkg::t_cmd     i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_out_full,
    output logic               o_out_push,
    output bsce_pkg::t_result  o_out_res
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int TW = AW + 2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WRITE = 5'b00010,
        S_SUM   = 5'b00100,
        S_DIV   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                           r_state;
    t_state                           n_state;
    bsce_pkg::t_cmd                   r_cmd;
    logic [AW-1:0]                    r_head;
    logic [bsce_pkg::CNT_BITS-1:0]    r_e;
    logic [bsce_pkg::CNT_BITS-1:0]    r_j;
    logic [bsce_pkg::SUM_BITS-1:0]    r_sum;
    logic                             r_rd_v;
    logic                             r_use_edge;
    logic [bsce_pkg::SAMPLE_BITS-1:0] r_rd_data;
    logic [bsce_pkg::SAMPLE_BITS-1:0] r_res;
    logic [bsce_pkg::SAMPLE_BITS-1:0] r_ring [MAX_WIDTH];

    logic [bsce_pkg::CNT_BITS:0]      eh;
    logic [bsce_pkg::CNT_BITS-1:0]    d;
    logic                             use_edge;
    logic [TW-1:0]                    tmp;
    logic [AW-1:0]                    rd_addr;
    logic                             issue;
    logic                             sum_done;
    logic                             div_done;
    logic [bsce_pkg::SUM_BITS-1:0]    quotient;
    logic [bsce_pkg::SAMPLE_BITS-1:0] add_val;

    bsce_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sum_done),
        .i_dividend (r_sum),
        .i_divisor  (r_cmd.w),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        eh = {1'b0, r_e} + {1'b0, r_cmd.half};
        if ({1'b0, r_j} > eh) begin
            d = '0;
        end else begin
            d = bsce_pkg::CNT_BITS'(eh - {1'b0, r_j});
        end
        use_edge = (d > r_cmd.p);
        tmp = TW'(r_head) + TW'(MAX_WIDTH - 1) - TW'(d);
        if (tmp >= TW'(MAX_WIDTH)) begin
            tmp = tmp - TW'(MAX_WIDTH);
        end
        rd_addr = tmp[AW-1:0];
        add_val = r_use_edge ? r_cmd.edge_smp : r_rd_data;
    end

    assign issue      = (r_state == S_SUM) && (r_j != r_cmd.w);
    assign sum_done   = (r_state == S_SUM) && (r_j == r_cmd.w) && !r_rd_v;
    assign o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_out_push = (r_state == S_EMIT) && !i_out_full;
    assign o_out_res  = '{smoothed: r_res, last_out: r_cmd.last && (r_e == '0)};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (r_cmd.pass) begin
                    n_state = S_EMIT;
                end else if (r_cmd.has_out) begin
                    n_state = S_SUM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SUM: begin
                if (sum_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_out_push) begin
                    n_state = (r_cmd.last && (r_e != '0)) ? S_SUM : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= issue;
            if (r_state == S_WRITE) begin
                r_head <= (r_head == AW'(MAX_WIDTH - 1)) ? '0 : r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        case (r_state)
            S_WRITE: begin
                r_e   <= r_cmd.pass ? '0 : r_cmd.e_first;
                r_res <= r_cmd.sample;
                r_j   <= '0;
                r_sum <= '0;
            end
            S_SUM: begin
                if (issue) begin
                    r_j <= r_j + 1'b1;
                end
                r_use_edge <= use_edge;
                if (r_rd_v) begin
                    r_sum <= r_sum + bsce_pkg::SUM_BITS'(add_val);
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_res <= quotient[bsce_pkg::SAMPLE_BITS-1:0];
                end
            end
            S_EMIT: begin
                if (o_out_push && r_cmd.last && (r_e != '0)) begin
                    r_e   <= r_e - 1'b1;
                    r_j   <= '0;
                    r_sum <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_ring[r_head] <= r_cmd.sample;
        end
        if (issue) begin
            r_rd_data <= r_ring[rd_addr];
        end
    end

endmodule

/* design/boxcar_smoother_clamped_edges_core.sv */
// Top level of the boxcar smoother with clamped frame edges.
// Depends on bsce_pkg, bsce_front, bsce_fifo and bsce_back.
//
// Samples enter through push/full and i_item; a transfer happens when push is
// high and full is low. Results leave through empty/pop and o_result; the
// oldest result is shown while empty is low and is taken when pop is high.
// i_cfg_we with i_cfg_wdata sets the window width (reset value 5, widths of 0
// or 1 pass samples through, widths above MAX_WIDTH act as MAX_WIDTH).
// The front accepts one sample per cycle into a two-entry command queue while
// that queue is not full. The back handles one command at a time: taking it and
// writing the ring, then for each smoothed result summing the window from the
// ring memory, dividing in the bit-serial divider and pushing into the result
// queue; a pass-through sample skips the summing and dividing. A frame end
// yields up to (W+1)/2 results in a row. When the receiver stalls, the
// two-entry result queue fills, the back waits, then the command queue fills
// and full rises. Reset empties both queues, restores the width and starts a
// new frame.
module boxcar_smoother_clamped_edges_core #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bsce_pkg::CNT_BITS-1:0] i_cfg_wdata,
    input  logic                          push,
    output logic                          full,
    input  bsce_pkg::t_item               i_item,
    output logic                          empty,
    input  logic                          pop,
    output bsce_pkg::t_result             o_result
);

    localparam int CMD_BITS = $bits(bsce_pkg::t_cmd);
    localparam int RES_BITS = $bits(bsce_pkg::t_result);

    bsce_pkg::t_cmd    front_cmd;
    bsce_pkg::t_cmd    back_cmd;
    bsce_pkg::t_result back_res;
    logic              cmd_push;
    logic              cmd_empty;
    logic              cmd_pop;
    logic              out_full;
    logic              out_push;
    logic [CMD_BITS-1:0] cmd_q_data;
    logic [RES_BITS-1:0] res_q_data;

    bsce_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_item      (i_item),
        .i_q_full    (full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (front_cmd)
    );

    bsce_fifo #(
        .WIDTH (CMD_BITS),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .o_full  (full),
        .o_empty (cmd_empty),
        .i_pop   (cmd_pop),
        .o_data  (cmd_q_data)
    );

    assign back_cmd = cmd_q_data;

    bsce_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (cmd_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out_res   (back_res)
    );

    bsce_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_res),
        .o_full  (out_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (res_q_data)
    );

    assign o_result = res_q_data;

endmodule
